/* rtl/q24_8_fixed_point_alu_core_macros.svh */
// assertion helpers used by the alu core
`ifndef Q24_8_FIXED_POINT_ALU_CORE_MACROS_SVH
`define Q24_8_FIXED_POINT_ALU_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define Q24_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication on a past value at a fixed distance
`define Q24_ASSERT_PAST(lbl, ante, sig, n, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> $past(sig, n)) \
		else $error(msg);

`endif

/* rtl/q24_pkg.sv */
package q24_pkg;

	localparam int FRAC_BITS = 8;
	localparam int DATA_W    = 32;
	localparam int NUM_W     = DATA_W + FRAC_BITS;
	localparam int DIV_STEPS = (NUM_W + 1) / 2;
	localparam int NUM_PAD_W = 2 * DIV_STEPS;
	localparam int REM_W     = DATA_W + 1;
	localparam int WIDE_W    = 64;
	// input register, three front stages, divider steps, output register
	localparam int PIPE_LAT  = DIV_STEPS + 5;

	localparam logic [DATA_W-1:0] MAX_POS = 32'h7fff_ffff;
	localparam logic [DATA_W-1:0] MIN_NEG = 32'h8000_0000;

	typedef enum logic [3:0] {
		CMD_ADD     = 4'd0,
		CMD_SUB     = 4'd1,
		CMD_MUL     = 4'd2,
		CMD_DIV     = 4'd3,
		CMD_GT      = 4'd4,
		CMD_LT      = 4'd5,
		CMD_GE      = 4'd6,
		CMD_LE      = 4'd7,
		CMD_EQ      = 4'd8,
		CMD_NE      = 4'd9,
		CMD_MIN     = 4'd10,
		CMD_MAX     = 4'd11,
		CMD_INC     = 4'd12,
		CMD_DEC     = 4'd13,
		CMD_TOINT   = 4'd14,
		CMD_FROMINT = 4'd15
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_OVF  = 2'd1,
		ST_DIV0 = 2'd2
	} status_t;

	typedef struct packed {
		logic [DATA_W-1:0] res;
		status_t           st;
	} res_t;

	typedef struct packed {
		logic              valid;
		logic              is_mul;
		logic              is_div;
		logic              neg;
		logic [DATA_W-1:0] res;
		logic              cmp;
		status_t           st;
	} side_t;

	typedef struct packed {
		logic [REM_W-1:0]     rem;
		logic [NUM_PAD_W-1:0] num;
		logic [DATA_W-1:0]    den;
	} div_t;

	function automatic res_t sat33(input logic [DATA_W:0] v);
		res_t r;
		if (v[DATA_W] != v[DATA_W-1]) begin
			r.res = v[DATA_W] ? MIN_NEG : MAX_POS;
			r.st  = ST_OVF;
		end else begin
			r.res = v[DATA_W-1:0];
			r.st  = ST_OK;
		end
		return r;
	endfunction

	// signed magnitude to 32 bits with saturation
	function automatic res_t sat_mag(input logic neg, input logic [WIDE_W-1:0] m);
		res_t r;
		r.st = ST_OK;
		if (neg) begin
			if (m > {{(WIDE_W-DATA_W){1'b0}}, MIN_NEG}) begin
				r.res = MIN_NEG;
				r.st  = ST_OVF;
			end else begin
				r.res = ~m[DATA_W-1:0] + {{(DATA_W-1){1'b0}}, 1'b1};
			end
		end else begin
			if (m > {{(WIDE_W-DATA_W){1'b0}}, MAX_POS}) begin
				r.res = MAX_POS;
				r.st  = ST_OVF;
			end else begin
				r.res = m[DATA_W-1:0];
			end
		end
		return r;
	endfunction

endpackage

/* rtl/q24_front.sv */
module q24_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           valid_s1,
	input  q24_pkg::cmd_t                  cmd_s1,
	input  logic signed [q24_pkg::DATA_W-1:0] a_s1,
	input  logic signed [q24_pkg::DATA_W-1:0] b_s1,
	output q24_pkg::side_t                 side_s4,
	output q24_pkg::div_t                  div_s4
);

	q24_pkg::side_t side_c, side_s2, side_s3;
	logic [q24_pkg::DATA_W-1:0] mag_a, mag_b, mag_a_s2, mag_b_s2, mag_a_s3, den_s3;
	logic [q24_pkg::WIDE_W-1:0] prod_s3;
	logic [q24_pkg::NUM_W-1:0]  fi;
	logic [q24_pkg::WIDE_W-1:0] mul_m;
	q24_pkg::res_t              sr, mr;

	assign mag_a = a_s1[q24_pkg::DATA_W-1] ? (~a_s1 + 1'b1) : a_s1;
	assign mag_b = b_s1[q24_pkg::DATA_W-1] ? (~b_s1 + 1'b1) : b_s1;
	assign fi    = {a_s1, {q24_pkg::FRAC_BITS{1'b0}}};

	always_comb begin
		side_c        = '0;
		side_c.valid  = valid_s1;
		side_c.neg    = a_s1[q24_pkg::DATA_W-1] ^ b_s1[q24_pkg::DATA_W-1];
		side_c.st     = q24_pkg::ST_OK;
		sr            = '0;
		case (cmd_s1)
			q24_pkg::CMD_ADD: begin
				sr = q24_pkg::sat33({a_s1[q24_pkg::DATA_W-1], a_s1}
					+ {b_s1[q24_pkg::DATA_W-1], b_s1});
				side_c.res = sr.res;
				side_c.st  = sr.st;
			end
			q24_pkg::CMD_SUB: begin
				sr = q24_pkg::sat33({a_s1[q24_pkg::DATA_W-1], a_s1}
					- {b_s1[q24_pkg::DATA_W-1], b_s1});
				side_c.res = sr.res;
				side_c.st  = sr.st;
			end
			q24_pkg::CMD_MUL: side_c.is_mul = 1'b1;
			q24_pkg::CMD_DIV: begin
				if (b_s1 == '0) side_c.st = q24_pkg::ST_DIV0;
				else side_c.is_div = 1'b1;
			end
			q24_pkg::CMD_GT:  side_c.cmp = a_s1 > b_s1;
			q24_pkg::CMD_LT:  side_c.cmp = a_s1 < b_s1;
			q24_pkg::CMD_GE:  side_c.cmp = a_s1 >= b_s1;
			q24_pkg::CMD_LE:  side_c.cmp = a_s1 <= b_s1;
			q24_pkg::CMD_EQ:  side_c.cmp = a_s1 == b_s1;
			q24_pkg::CMD_NE:  side_c.cmp = a_s1 != b_s1;
			q24_pkg::CMD_MIN: side_c.res = (a_s1 < b_s1) ? a_s1 : b_s1;
			q24_pkg::CMD_MAX: side_c.res = (a_s1 > b_s1) ? a_s1 : b_s1;
			q24_pkg::CMD_INC: begin
				sr = q24_pkg::sat33({a_s1[q24_pkg::DATA_W-1], a_s1} + 33'd1);
				side_c.res = sr.res;
				side_c.st  = sr.st;
			end
			q24_pkg::CMD_DEC: begin
				sr = q24_pkg::sat33({a_s1[q24_pkg::DATA_W-1], a_s1} - 33'd1);
				side_c.res = sr.res;
				side_c.st  = sr.st;
			end
			q24_pkg::CMD_TOINT: side_c.res = a_s1 >>> q24_pkg::FRAC_BITS;
			default: begin
				// fits when the bits shifted past the sign all match it
				if (~|fi[q24_pkg::NUM_W-1:q24_pkg::DATA_W-1]
						|| &fi[q24_pkg::NUM_W-1:q24_pkg::DATA_W-1]) begin
					side_c.res = fi[q24_pkg::DATA_W-1:0];
				end else begin
					side_c.res = a_s1[q24_pkg::DATA_W-1] ? q24_pkg::MIN_NEG : q24_pkg::MAX_POS;
					side_c.st  = q24_pkg::ST_OVF;
				end
			end
		endcase
	end

	// round half away from zero on the product magnitude
	assign mul_m = (prod_s3 + ({{(q24_pkg::WIDE_W-1){1'b0}}, 1'b1}
		<< (q24_pkg::FRAC_BITS - 1))) >> q24_pkg::FRAC_BITS;
	assign mr = q24_pkg::sat_mag(side_s3.neg, mul_m);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
			side_s3 <= '0;
			side_s4 <= '0;
		end else begin
			side_s2 <= side_c;
			side_s3 <= side_s2;
			side_s4.valid  <= side_s3.valid;
			side_s4.is_mul <= side_s3.is_mul;
			side_s4.is_div <= side_s3.is_div;
			side_s4.neg    <= side_s3.neg;
			side_s4.cmp    <= side_s3.cmp;
			side_s4.res    <= side_s3.is_mul ? mr.res : side_s3.res;
			side_s4.st     <= side_s3.is_mul ? mr.st : side_s3.st;
		end
	end

	always_ff @(posedge clk) begin
		mag_a_s2 <= mag_a;
		mag_b_s2 <= mag_b;

		prod_s3  <= mag_a_s2 * mag_b_s2;
		mag_a_s3 <= mag_a_s2;
		den_s3   <= mag_b_s2;

		div_s4.rem     <= '0;
		div_s4.num     <= {{(q24_pkg::NUM_PAD_W-q24_pkg::NUM_W){1'b0}}, mag_a_s3,
			{q24_pkg::FRAC_BITS{1'b0}}};
		div_s4.den     <= den_s3;
	end

endmodule

/* rtl/q24_div_step.sv */
module q24_div_step (
	input  logic           clk,
	input  logic           arst_n,
	input  q24_pkg::side_t side_in,
	input  q24_pkg::div_t  div_in,
	output q24_pkg::side_t side_out,
	output q24_pkg::div_t  div_out
);

	logic [q24_pkg::REM_W-1:0]     r, t;
	logic [q24_pkg::NUM_PAD_W-1:0] n;
	logic                          q;

	// two restoring steps; quotient bits shift into the low end of num
	always_comb begin
		r = div_in.rem;
		n = div_in.num;
		t = '0;
		q = 1'b0;
		for (int i = 0; i < 2; i++) begin
			t = {r[q24_pkg::REM_W-2:0], n[q24_pkg::NUM_PAD_W-1]};
			q = t >= {1'b0, div_in.den};
			r = q ? (t - {1'b0, div_in.den}) : t;
			n = {n[q24_pkg::NUM_PAD_W-2:0], q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) side_out <= '0;
		else side_out <= side_in;
	end

	always_ff @(posedge clk) begin
		div_out.rem <= r;
		div_out.num <= n;
		div_out.den <= div_in.den;
	end

endmodule

/* rtl/q24_finish.sv */
module q24_finish (
	input  logic                              clk,
	input  logic                              arst_n,
	input  q24_pkg::side_t                    side_in,
	input  q24_pkg::div_t                     div_in,
	output logic                              done,
	output logic signed [q24_pkg::DATA_W-1:0] result,
	output logic                              compare_true,
	output logic [1:0]                        status
);

	logic                       up;
	logic [q24_pkg::WIDE_W-1:0] m;
	q24_pkg::res_t              dr;

	// quotient rounds up when twice the remainder reaches the divisor
	assign up = {div_in.rem, 1'b0} >= {2'b00, div_in.den};
	assign m  = {{(q24_pkg::WIDE_W-q24_pkg::NUM_PAD_W){1'b0}}, div_in.num}
		+ {{(q24_pkg::WIDE_W-1){1'b0}}, up};
	assign dr = q24_pkg::sat_mag(side_in.neg, m);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= side_in.valid;
	end

	always_ff @(posedge clk) begin
		result       <= side_in.is_div ? dr.res : side_in.res;
		status       <= side_in.is_div ? dr.st : side_in.st;
		compare_true <= side_in.cmp;
	end

endmodule

/* rtl/q24_8_fixed_point_alu_core.sv */
// channel  | transfer when   | signals
// ---------+-----------------+----------------------------------------
// command  | start && !busy  | command, operand_a, operand_b
// result   | done            | result, compare_true, status
//
// one command enters per cycle; busy stays low
// done follows the transfer through the input register, the front stages,
// the divider chain at two quotient bits per stage and the output register
// every command runs the full pipeline, so results leave in order
// reset clears the valid bits and side registers; results cannot be held off
`include "q24_8_fixed_point_alu_core_macros.svh"

module q24_8_fixed_point_alu_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [3:0]                        command,
	input  logic signed [q24_pkg::DATA_W-1:0] operand_a,
	input  logic signed [q24_pkg::DATA_W-1:0] operand_b,
	output logic                              done,
	output logic signed [q24_pkg::DATA_W-1:0] result,
	output logic                              compare_true,
	output logic [1:0]                        status
);

	logic                              valid_s1;
	q24_pkg::cmd_t                     cmd_s1;
	logic signed [q24_pkg::DATA_W-1:0] a_s1, b_s1;
	q24_pkg::side_t                    side_c [0:q24_pkg::DIV_STEPS];
	q24_pkg::div_t                     div_c  [0:q24_pkg::DIV_STEPS];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else valid_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		cmd_s1 <= q24_pkg::cmd_t'(command);
		a_s1   <= operand_a;
		b_s1   <= operand_b;
	end

	q24_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.cmd_s1   (cmd_s1),
		.a_s1     (a_s1),
		.b_s1     (b_s1),
		.side_s4  (side_c[0]),
		.div_s4   (div_c[0])
	);

	for (genvar g = 0; g < q24_pkg::DIV_STEPS; g++) begin : g_div
		q24_div_step u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.side_in  (side_c[g]),
			.div_in   (div_c[g]),
			.side_out (side_c[g+1]),
			.div_out  (div_c[g+1])
		);
	end

	q24_finish u_finish (
		.clk          (clk),
		.arst_n       (arst_n),
		.side_in      (side_c[q24_pkg::DIV_STEPS]),
		.div_in       (div_c[q24_pkg::DIV_STEPS]),
		.done         (done),
		.result       (result),
		.compare_true (compare_true),
		.status       (status)
	);

	`Q24_ASSERT_PAST(a_done_has_cmd, done, start, q24_pkg::PIPE_LAT, "result without command")
	`Q24_ASSERT_IMP(a_div0_zero, done && status == q24_pkg::ST_DIV0, result == '0,
		"divide by zero with nonzero result")
	`Q24_ASSERT_IMP(a_ovf_limit, done && status == q24_pkg::ST_OVF,
		result == q24_pkg::MAX_POS || result == q24_pkg::MIN_NEG, "overflow not saturated")
	`Q24_ASSERT_IMP(a_cmp_clean, done && compare_true,
		result == '0 && status == q24_pkg::ST_OK, "compare with result or status")

endmodule

/* test/q24_8_fixed_point_alu_core_test.sv */
module q24_8_fixed_point_alu_core_test;
	import q24_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 850;

	typedef struct packed {
		logic [31:0] res;
		logic        cmp;
		logic [1:0]  st;
	} alu_out_t;

	typedef struct {
		cmd_t        op;
		logic [31:0] a;
		logic [31:0] b;
		logic        typed;
		alu_out_t    want;
	} vector_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [3:0] command = '0;
	logic signed [31:0] operand_a = '0;
	logic signed [31:0] operand_b = '0;
	logic busy, done, compare_true;
	logic signed [31:0] result;
	logic [1:0] status;

	alu_out_t pending_results[$];
	int errors = 0;
	int idle_cycles = 0;
	int send_gap_pct = 20;
	vector_t vectors[$];

	q24_8_fixed_point_alu_core dut (.*);

	always #5 clk = ~clk;

	function automatic alu_out_t make_out(logic [31:0] r, logic c, status_t s);
		alu_out_t o;
		o.res = r;
		o.cmp = c;
		o.st = s;
		return o;
	endfunction

	function automatic alu_out_t saturate(logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return make_out(MAX_POS, 1'b0, ST_OVF);
		if (v < -64'sd2147483648)
			return make_out(MIN_NEG, 1'b0, ST_OVF);
		return make_out(v[31:0], 1'b0, ST_OK);
	endfunction

	function automatic alu_out_t signed_mag(logic neg, logic [63:0] m);
		if (neg) begin
			if (m > 64'h8000_0000)
				return make_out(MIN_NEG, 1'b0, ST_OVF);
			return make_out(-m[31:0], 1'b0, ST_OK);
		end
		if (m > 64'h7fff_ffff)
			return make_out(MAX_POS, 1'b0, ST_OVF);
		return make_out(m[31:0], 1'b0, ST_OK);
	endfunction

	function automatic alu_out_t alu_predict(cmd_t op, logic [31:0] ua, logic [31:0] ub);
		logic signed [63:0] a, b;
		logic [63:0] ma, mb, m;
		logic neg;
		a = $signed(ua);
		b = $signed(ub);
		ma = a < 0 ? -a : a;
		mb = b < 0 ? -b : b;
		neg = (a < 0) != (b < 0);
		case (op)
			CMD_ADD: return saturate(a + b);
			CMD_SUB: return saturate(a - b);
			CMD_MUL: begin
				m = (ma * mb + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
				return signed_mag(neg && m != 0, m);
			end
			CMD_DIV: begin
				if (b == 0)
					return make_out('0, 1'b0, ST_DIV0);
				m = (2 * (ma << FRAC_BITS) + mb) / (2 * mb);
				return signed_mag(neg && m != 0, m);
			end
			CMD_GT: return make_out('0, a > b, ST_OK);
			CMD_LT: return make_out('0, a < b, ST_OK);
			CMD_GE: return make_out('0, a >= b, ST_OK);
			CMD_LE: return make_out('0, a <= b, ST_OK);
			CMD_EQ: return make_out('0, a == b, ST_OK);
			CMD_NE: return make_out('0, a != b, ST_OK);
			CMD_MIN: return make_out(a < b ? ua : ub, 1'b0, ST_OK);
			CMD_MAX: return make_out(a > b ? ua : ub, 1'b0, ST_OK);
			CMD_INC: return saturate(a + 1);
			CMD_DEC: return saturate(a - 1);
			CMD_TOINT: return make_out($signed(ua) >>> FRAC_BITS, 1'b0, ST_OK);
			default: return saturate(a * (64'sd1 << FRAC_BITS));
		endcase
	endfunction

	function automatic void add_row(cmd_t op, logic [31:0] a, logic [31:0] b, logic typed,
			logic [31:0] r, logic c, status_t s);
		vector_t v;
		v.op = op;
		v.a = a;
		v.b = b;
		v.typed = typed;
		v.want = make_out(r, c, s);
		vectors.push_back(v);
	endfunction

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 3) == 0 ? MAX_POS : MIN_NEG;
			1: return $signed($urandom_range(0, 1024)) - 512;
			2: return $urandom & 32'h0000_ffff;
			3: return {{16{1'b1}}, 16'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	task automatic send(cmd_t op, logic [31:0] a, logic [31:0] b);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		command <= op;
		operand_a <= a;
		operand_b <= b;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// accept on the sender side and compare results
	always @(posedge clk) begin
		alu_out_t w;
		if (arst_n) begin
			if (start && !busy) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (done) begin
				if (pending_results.size() == 0) begin
					$error("unexpected result transfer");
					errors++;
				end else begin
					w = pending_results.pop_front();
					if (result !== w.res) begin
						$error("result: expected %h actual %h", w.res, result);
						errors++;
					end
					if (compare_true !== w.cmp) begin
						$error("compare_true: expected %b actual %b", w.cmp, compare_true);
						errors++;
					end
					if (status !== w.st) begin
						$error("status: expected %0d actual %0d", w.st, status);
						errors++;
					end
				end
			end
			if (idle_cycles > STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	// expected results are queued at the accepting edge
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			pending_results.push_back(alu_predict(cmd_t'(command), operand_a, operand_b));
	end

	initial begin
		int row;
		int n;
		cmd_t op;
		add_row(CMD_ADD, MAX_POS, 32'd1, 1'b1, MAX_POS, 1'b0, ST_OVF);
		add_row(CMD_ADD, MIN_NEG, 32'hffff_ffff, 1'b1, MIN_NEG, 1'b0, ST_OVF);
		add_row(CMD_SUB, MIN_NEG, 32'd1, 1'b1, MIN_NEG, 1'b0, ST_OVF);
		add_row(CMD_SUB, 32'd5, 32'd3, 1'b1, 32'd2, 1'b0, ST_OK);
		add_row(CMD_MUL, 32'h100, 32'h180, 1'b1, 32'h180, 1'b0, ST_OK);
		add_row(CMD_MUL, MIN_NEG, MIN_NEG, 1'b1, MAX_POS, 1'b0, ST_OVF);
		add_row(CMD_MUL, 32'd1, 32'h80, 1'b0, 32'd0, 1'b0, ST_OK);
		add_row(CMD_MUL, 32'hffff_ffff, 32'h80, 1'b0, 32'd0, 1'b0, ST_OK);
		add_row(CMD_DIV, 32'h100, 32'd0, 1'b1, 32'd0, 1'b0, ST_DIV0);
		add_row(CMD_DIV, MIN_NEG, 32'd1, 1'b1, MIN_NEG, 1'b0, ST_OVF);
		add_row(CMD_DIV, 32'd1, 32'd3, 1'b0, 32'd0, 1'b0, ST_OK);
		add_row(CMD_DIV, MIN_NEG, 32'hffff_ffff, 1'b0, 32'd0, 1'b0, ST_OK);
		add_row(CMD_GT, MAX_POS, MIN_NEG, 1'b1, 32'd0, 1'b1, ST_OK);
		add_row(CMD_LT, MAX_POS, MIN_NEG, 1'b1, 32'd0, 1'b0, ST_OK);
		add_row(CMD_GE, 32'd7, 32'd7, 1'b1, 32'd0, 1'b1, ST_OK);
		add_row(CMD_LE, 32'd8, 32'd7, 1'b1, 32'd0, 1'b0, ST_OK);
		add_row(CMD_EQ, 32'd7, 32'd7, 1'b1, 32'd0, 1'b1, ST_OK);
		add_row(CMD_NE, 32'd7, 32'd7, 1'b1, 32'd0, 1'b0, ST_OK);
		add_row(CMD_MIN, MIN_NEG, MAX_POS, 1'b1, MIN_NEG, 1'b0, ST_OK);
		add_row(CMD_MAX, MIN_NEG, MAX_POS, 1'b1, MAX_POS, 1'b0, ST_OK);
		add_row(CMD_INC, MAX_POS, 32'hffff_ffff, 1'b1, MAX_POS, 1'b0, ST_OVF);
		add_row(CMD_DEC, MIN_NEG, 32'hffff_ffff, 1'b1, MIN_NEG, 1'b0, ST_OVF);
		add_row(CMD_TOINT, 32'hffff_ff01, 32'd0, 1'b1, 32'hffff_ffff, 1'b0, ST_OK);
		add_row(CMD_FROMINT, 32'h0080_0000, 32'd0, 1'b1, MAX_POS, 1'b0, ST_OVF);
		add_row(CMD_FROMINT, 32'hff80_0000, 32'd0, 1'b1, MIN_NEG, 1'b0, ST_OK);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_gap_pct = 0;
		for (row = 0; row < vectors.size(); row++) begin
			if (vectors[row].typed &&
					alu_predict(vectors[row].op, vectors[row].a, vectors[row].b)
					!== vectors[row].want) begin
				$error("row %0d: table and predictor disagree", row);
				errors++;
			end
			send(vectors[row].op, vectors[row].a, vectors[row].b);
		end

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			send_gap_pct = n < RANDOM_ITEMS / 3 ? 20 : (n < 2 * RANDOM_ITEMS / 3 ? 81 : 0);
			op = cmd_t'($urandom_range(0, 15));
			send(op, rand_operand(), $urandom_range(0, 15) == 0 ? 32'd0 : rand_operand());
		end
		start <= 1'b0;

		n = 0;
		while (pending_results.size() != 0 && n < STALL_LIMIT) begin
			@(posedge clk);
			n++;
		end
		repeat (PIPE_LAT + 5) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
